FILE: rtl/cst_pkg.sv
// Shared types and constants for the client/server time sync block.
// No dependencies; used by cst_core and client_server_time_sync.
package cst_pkg;

  localparam int unsigned TimeW = 31;
  localparam int unsigned OffW  = 32;
  localparam int unsigned ThrW  = 12;
  localparam int unsigned NudgeW = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 12;

  localparam logic [ThrW-1:0] ResetThrDefault = 12'd500;
  localparam logic [ThrW-1:0] FastThrDefault  = 12'd100;
  localparam logic signed [NudgeW-1:0] NudgeMin = -6'sd30;
  localparam logic signed [NudgeW-1:0] NudgeMax = 6'sd30;
  localparam logic [TimeW-1:0] ExtrapWindow = 31'd5;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RESET_THR = 3'd0,
    REG_FAST_THR  = 3'd1,
    REG_NUDGE     = 3'd2,
    REG_DRIFT_EN  = 3'd3,
    REG_HOLD      = 3'd4,
    REG_PAUSE     = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ADJ_NONE  = 3'd0,
    ADJ_RESET = 3'd1,
    ADJ_FAST  = 3'd2,
    ADJ_SLOW  = 3'd3,
    ADJ_LOCK  = 3'd4
  } adjust_kind_e;

  typedef struct packed {
    logic [ThrW-1:0]          reset_threshold;
    logic [ThrW-1:0]          fast_threshold;
    logic signed [NudgeW-1:0] time_nudge;
    logic                     drift_enable;
    logic                     hold_offset;
    logic                     pause;
  } cfg_t;

  typedef struct packed {
    logic                     synced;
    logic signed [OffW-1:0]   time_offset;
    logic [TimeW-1:0]         last_output_time;
    logic [TimeW-1:0]         last_snap_time;
    logic                     extrap;
  } state_t;

  typedef struct packed {
    logic [TimeW-1:0] local_time;
    logic [TimeW-1:0] snap_time;
    logic             new_snap;
    logic             snap_active;
  } item_t;

  typedef struct packed {
    logic [TimeW-1:0] server_time;
    logic             synced;
    adjust_kind_e     adjust_kind;
    logic             time_error;
    logic             extrapolating;
  } result_t;

endpackage

FILE: rtl/cst_core.sv
// One-tick update of the time sync state: lock, frame time, offset adjust.
// Purely combinational; depends on cst_pkg.
module cst_core import cst_pkg::*; (
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t result_o
);

  localparam logic signed [OffW:0] OffMax33 = 33'sh0_7FFF_FFFF;
  localparam logic signed [OffW:0] OffMin33 = -33'sh0_8000_0000;

  logic                    lock;
  logic                    fresh;
  logic                    synced_n;
  logic signed [OffW-1:0]  new_off;
  logic signed [OffW-1:0]  off_e;
  logic [TimeW-1:0]        lout_e;
  logic signed [OffW+1:0]  sum;
  logic signed [OffW+1:0]  st;
  logic [TimeW-1:0]        st_c;
  logic signed [OffW+1:0]  dd;
  logic [OffW+1:0]         dd_abs;
  logic signed [OffW:0]    avg;
  logic signed [OffW:0]    drift;
  logic                    ext_n;

  always_comb begin
    lock    = !state_i.synced && item_i.new_snap && item_i.snap_active;
    fresh   = state_i.synced && item_i.new_snap;
    synced_n = state_i.synced | lock;
    new_off = OffW'(signed'({1'b0, item_i.snap_time})) - OffW'(signed'({1'b0, item_i.local_time}));
    off_e   = lock ? new_off : state_i.time_offset;
    lout_e  = lock ? item_i.snap_time : state_i.last_output_time;

    sum = signed'({3'b000, item_i.local_time}) + (OffW+2)'(off_e);
    st  = sum - (OffW+2)'(cfg_i.time_nudge);
    if (st < 0) begin
      st_c = '0;
    end else if (st > signed'({3'b000, {TimeW{1'b1}}})) begin
      st_c = {TimeW{1'b1}};
    end else begin
      st_c = st[TimeW-1:0];
    end
    if (st_c < lout_e) st_c = lout_e;

    // extrapolating once local + offset reaches within the window of the snapshot
    ext_n = state_i.extrap |
            (sum >= signed'({3'b000, item_i.snap_time}) - signed'((OffW+2)'(ExtrapWindow)));

    dd     = (OffW+2)'(new_off) - (OffW+2)'(off_e);
    dd_abs = dd[OffW+1] ? unsigned'(-dd) : unsigned'(dd);
    avg    = ((OffW+1)'(off_e) + (OffW+1)'(new_off)) >>> 1;
    drift  = ext_n ? (OffW+1)'(off_e) - (OffW+1)'(2) : (OffW+1)'(off_e) + (OffW+1)'(1);
    if (drift > OffMax33) drift = OffMax33;
    if (drift < OffMin33) drift = OffMin33;

    state_o = state_i;
    state_o.synced = synced_n;
    state_o.time_offset = off_e;
    state_o.last_output_time = lout_e;
    result_o.server_time   = lout_e;
    result_o.synced        = synced_n;
    result_o.adjust_kind   = lock ? ADJ_LOCK : ADJ_NONE;
    result_o.time_error    = 1'b0;
    result_o.extrapolating = state_i.extrap;

    if (synced_n && !cfg_i.pause) begin
      result_o.time_error = item_i.snap_time < state_i.last_snap_time;
      state_o.last_snap_time = item_i.snap_time;
      state_o.last_output_time = st_c;
      result_o.server_time = st_c;
      state_o.extrap = ext_n;
      if (fresh && !cfg_i.hold_offset) begin
        if (dd_abs > (OffW+2)'(cfg_i.reset_threshold)) begin
          state_o.time_offset = new_off;
          state_o.last_output_time = item_i.snap_time;
          result_o.server_time = item_i.snap_time;
          result_o.adjust_kind = ADJ_RESET;
        end else if (dd_abs > (OffW+2)'(cfg_i.fast_threshold)) begin
          state_o.time_offset = avg[OffW-1:0];
          result_o.adjust_kind = ADJ_FAST;
        end else if (cfg_i.drift_enable) begin
          state_o.extrap = 1'b0;
          state_o.time_offset = drift[OffW-1:0];
          result_o.adjust_kind = ADJ_SLOW;
        end
      end
      result_o.extrapolating = state_o.extrap;
    end
  end

endmodule

FILE: rtl/client_server_time_sync.sv
// Top level of the client/server time sync block: stream ports, config registers.
// Depends on cst_pkg and cst_core.

// One beat in per frame tick, one result beat out. A beat lands in an input
// register, and the whole update (lock, frame time, offset adjust) runs
// combinationally as it moves into the output register, so the block takes one
// beat per cycle while the output is not stalled by m_axis_tready. The input
// register refills in the same cycle the output register is drained.
// Configuration writes take effect at the next clock edge; write only while
// no beat is in flight.
module client_server_time_sync import cst_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [63:0]         s_axis_tdata,  // local_time[30:0], snap_time[61:31], zero pad
  input  logic [1:0]          s_axis_tuser,  // new_snap[0], snap_active[1]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,  // server_time[30:0], zero pad
  output logic [5:0]          m_axis_tuser,  // synced[0], adjust_kind[3:1],
                                             // time_error[4], extrapolating[5]
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  item_t   in_q;
  logic    in_valid_q;
  result_t res_q, res_d;
  logic    out_valid_q;
  logic    adv;
  logic signed [NudgeW-1:0] nudge_w;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  cst_core u_core (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (in_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_comb begin
    nudge_w = signed'(cfg_data_i[NudgeW-1:0]);
    if (nudge_w < NudgeMin) nudge_w = NudgeMin;
    if (nudge_w > NudgeMax) nudge_w = NudgeMax;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_threshold <= ResetThrDefault;
      cfg_q.fast_threshold  <= FastThrDefault;
      cfg_q.time_nudge      <= '0;
      cfg_q.drift_enable    <= 1'b1;
      cfg_q.hold_offset     <= 1'b0;
      cfg_q.pause           <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RESET_THR: cfg_q.reset_threshold <= cfg_data_i[ThrW-1:0];
        REG_FAST_THR:  cfg_q.fast_threshold  <= cfg_data_i[ThrW-1:0];
        REG_NUDGE:     cfg_q.time_nudge      <= nudge_w;
        REG_DRIFT_EN:  cfg_q.drift_enable    <= cfg_data_i[0];
        REG_HOLD:      cfg_q.hold_offset     <= cfg_data_i[0];
        REG_PAUSE:     cfg_q.pause           <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) state_q <= state_d;
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.local_time  <= s_axis_tdata[TimeW-1:0];
      in_q.snap_time   <= s_axis_tdata[2*TimeW-1:TimeW];
      in_q.new_snap    <= s_axis_tuser[0];
      in_q.snap_active <= s_axis_tuser[1];
    end
    if (adv) res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q.server_time};
  assign m_axis_tuser  = {res_q.extrapolating, res_q.time_error,
                          res_q.adjust_kind, res_q.synced};

endmodule
